FILE: src/hfvt_pkg.sv
// shared constants, types and helpers for the heavy flow vote table
package hfvt_pkg;

  localparam int unsigned DEF_MAX_BUCKETS = 1024;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned CFG_BU_W        = 11;
  localparam int unsigned MIX_SHIFT       = 16;
  localparam logic [KEY_W-1:0] MIX_MULT   = 32'h045d_9f3b;
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;

  localparam logic REG_BUCKETS = 1'b0;
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_QUERY   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] reward;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

FILE: src/heavy_flow_vote_table_core.sv
// heavy flow vote table top: control, bucket update, config port
// one request at a time: busy falls in the cycle of the result strobe, when the next start can be taken
// a request passes two hash multiply stages, the 32 step serial remainder of the hash by bu_r,
// one table read and the write-back
// after reset a clearing pass writes every bucket with busy high
// results are not held: each shows for one cycle under out_valid
module heavy_flow_vote_table_core
  import hfvt_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = DEF_MAX_BUCKETS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [KEY_W-1:0] in_flow_key,
  output logic             out_valid,
  output logic             out_evicted,
  output logic [KEY_W-1:0] out_evicted_key,
  output logic [CNT_W-1:0] out_evicted_total,
  output logic [CNT_W-1:0] out_query_count,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned IDX_W = $clog2(MAX_BUCKETS);
  localparam int unsigned BU_W  = $clog2(MAX_BUCKETS + 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_MOD   = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  state_t            state_r;
  state_t            state_nxt;
  logic [IDX_W-1:0]  clr_r;
  logic [IDX_W-1:0]  idx_r;
  logic [BU_W-1:0]   bu_r;
  logic [BU_W-1:0]   bu_nxt;
  logic              type_r;
  logic [KEY_W-1:0]  key_r;
  logic              accept;
  logic              cfg_we;
  logic [CFG_BU_W-1:0] cfg_v;

  logic              hash_valid;
  logic [KEY_W-1:0]  hash;
  logic              mod_done;
  logic [BU_W-1:0]   mod_rem;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wdata;
  logic              ram_re;
  slot_t             ram_rdata;
  logic [SLOT_W-1:0] ram_rdata_bits;

  slot_t             upd_slot;
  logic              upd_write;
  logic              upd_evicted;
  logic [CNT_W-1:0]  upd_qcount;
  logic [CNT_W-1:0]  rew_dec;

  logic              out_valid_r;
  logic              out_evicted_r;
  logic [KEY_W-1:0]  out_evicted_key_r;
  logic [CNT_W-1:0]  out_evicted_total_r;
  logic [CNT_W-1:0]  out_query_count_r;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_BUCKETS);
  assign cfg_v  = pwdata[CFG_BU_W-1:0];
  assign prdata = (paddr[2] == REG_BUCKETS) ? 32'(bu_r) : '0;

  always_comb begin
    if (cfg_v == '0) begin
      bu_nxt = BU_W'(1);
    end else if (32'(cfg_v) > 32'(MAX_BUCKETS)) begin
      bu_nxt = BU_W'(MAX_BUCKETS);
    end else begin
      bu_nxt = BU_W'(cfg_v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bu_r <= BU_W'(MAX_BUCKETS);
    end else if (cfg_we) begin
      bu_r <= bu_nxt;
    end
  end

  hfvt_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .key       (in_flow_key),
    .out_valid (hash_valid),
    .hash      (hash)
  );

  hfvt_mod #(
    .DIV_W (BU_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (hash_valid),
    .dividend (hash),
    .divisor  (bu_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  hfvt_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (mod_rem[IDX_W-1:0]),
    .rdata (ram_rdata_bits)
  );

  assign ram_rdata = slot_t'(ram_rdata_bits);
  assign ram_re    = mod_done;

  // bucket update
  assign rew_dec = (ram_rdata.reward != '0) ? ram_rdata.reward - CNT_W'(1) : '0;

  always_comb begin
    upd_slot    = ram_rdata;
    upd_write   = 1'b0;
    upd_evicted = 1'b0;
    upd_qcount  = '0;
    if (type_r == REQ_QUERY) begin
      if (ram_rdata.key == key_r) begin
        upd_qcount = ram_rdata.count;
      end
    end else if (ram_rdata.count == '0) begin
      upd_write = 1'b1;
      upd_slot  = '{key: key_r, count: CNT_W'(1), reward: CNT_W'(1)};
    end else if (ram_rdata.key == key_r) begin
      upd_write    = 1'b1;
      upd_slot.count  = sat_inc(ram_rdata.count);
      upd_slot.reward = sat_inc(ram_rdata.reward);
    end else if (rew_dec == '0) begin
      upd_write   = 1'b1;
      upd_evicted = 1'b1;
      upd_slot    = '{key: key_r, count: CNT_W'(1), reward: CNT_W'(1)};
    end else begin
      upd_write       = 1'b1;
      upd_slot.reward = rew_dec;
    end
  end

  assign ram_we    = (state_r == ST_CLEAR) || ((state_r == ST_READ) && upd_write);
  assign ram_waddr = (state_r == ST_CLEAR) ? clr_r : idx_r;
  assign ram_wdata = (state_r == ST_CLEAR) ? slot_t'('0) : upd_slot;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == IDX_W'(MAX_BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_valid) begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_READ);
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      type_r <= in_req_type;
      key_r  <= in_flow_key;
    end
    if (mod_done) begin
      idx_r <= mod_rem[IDX_W-1:0];
    end
    if (state_r == ST_READ) begin
      out_evicted_r       <= upd_evicted;
      out_evicted_key_r   <= upd_evicted ? ram_rdata.key : '0;
      out_evicted_total_r <= upd_evicted ? ram_rdata.count : '0;
      out_query_count_r   <= upd_qcount;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_evicted       = out_evicted_r;
  assign out_evicted_key   = out_evicted_key_r;
  assign out_evicted_total = out_evicted_total_r;
  assign out_query_count   = out_query_count_r;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy) else $error("busy not raised after start");

  a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == ST_MOD)) else $error("remainder done outside mod state");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != ST_IDLE)) else $error("table write while idle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result beat while busy");

  a_evict_no_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (out_query_count == '0))
    else $error("eviction beat carries a query count");
`endif

endmodule

FILE: src/hfvt_ram.sv
// generic simple dual port ram with registered read
module hfvt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/hfvt_hash.sv
// two stage multiply-xorshift key mix
module hfvt_hash
  import hfvt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [KEY_W-1:0] key,
  output logic             out_valid,
  output logic [KEY_W-1:0] hash
);

  logic [KEY_W-1:0] s1_r;
  logic [KEY_W-1:0] s2_r;
  logic             v1_r;
  logic             v2_r;
  logic [KEY_W-1:0] x0;
  logic [KEY_W-1:0] x1;

  assign x0 = (key >> MIX_SHIFT) ^ key;
  assign x1 = (s1_r >> MIX_SHIFT) ^ s1_r;

  always_ff @(posedge clk) begin
    s1_r <= x0 * MIX_MULT;
    s2_r <= x1 * MIX_MULT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  assign out_valid = v2_r;
  assign hash      = (s2_r >> MIX_SHIFT) ^ s2_r;

endmodule

FILE: src/hfvt_mod.sv
// bit serial remainder of the hash by the bucket count
module hfvt_mod
  import hfvt_pkg::*;
#(
  parameter int unsigned DIV_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] rem
);

  localparam int unsigned STEP_W = $clog2(KEY_W);

  logic [KEY_W-1:0]  dvd_r;
  logic [DIV_W-1:0]  div_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  rem_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DIV_W:0]    shifted;

  assign shifted = {rem_r, dvd_r[KEY_W-1]};

  always_comb begin
    if (shifted >= {1'b0, div_r}) begin
      rem_nxt = DIV_W'(shifted - {1'b0, div_r});
    end else begin
      rem_nxt = DIV_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(KEY_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: tb/sv/tb_heavy_flow_vote_table_core.sv
// testbench for the heavy flow vote table core: mirrored bucket table, pooled flows, apb setup
module tb_heavy_flow_vote_table_core;
  import hfvt_pkg::*;

  localparam int unsigned UNUSED_REG  = 1;
  localparam logic [2:0]  BUCKETS_ADR = 3'(4 * REG_BUCKETS);
  localparam logic [2:0]  UNUSED_ADR  = 3'(4 * UNUSED_REG);
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned POOL_N      = 12;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned N_PHASES    = 9;

  typedef struct packed {
    logic             evicted;
    logic [KEY_W-1:0] ev_key;
    logic [CNT_W-1:0] ev_total;
    logic [CNT_W-1:0] q_count;
  } flow_result_t;

  class flow_table_mirror;
    logic [KEY_W-1:0] key_mem[DEF_MAX_BUCKETS];
    logic [CNT_W-1:0] count_mem[DEF_MAX_BUCKETS];
    logic [CNT_W-1:0] reward_mem[DEF_MAX_BUCKETS];
    int unsigned      n_buckets;
    flow_result_t     expected_q[$];
    int unsigned      errors;
    int unsigned      n_inserts;
    int unsigned      n_queries;
    int unsigned      n_evictions;
    int unsigned      n_settings;

    function new();
      foreach (key_mem[i]) begin
        key_mem[i]    = '0;
        count_mem[i]  = '0;
        reward_mem[i] = '0;
      end
      n_buckets   = DEF_MAX_BUCKETS;
      errors      = 0;
      n_inserts   = 0;
      n_queries   = 0;
      n_evictions = 0;
      n_settings  = 0;
    endfunction

    function int unsigned bucket_index(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] h;
      h = key;
      h = ((h >> MIX_SHIFT) ^ h) * MIX_MULT;
      h = ((h >> MIX_SHIFT) ^ h) * MIX_MULT;
      h = (h >> MIX_SHIFT) ^ h;
      return h % n_buckets;
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function void set_reg(int unsigned index, logic [31:0] data);
      logic [CFG_BU_W-1:0] v;
      v = data[CFG_BU_W-1:0];
      if (index != REG_BUCKETS) return;
      n_settings++;
      if (v == 0) v = 1;
      if (v > DEF_MAX_BUCKETS) v = DEF_MAX_BUCKETS;
      n_buckets = v;
    endfunction

    function void take_request(logic req, logic [KEY_W-1:0] key);
      int unsigned  b;
      flow_result_t r;
      b = bucket_index(key);
      r = '0;
      if (req == REQ_QUERY) begin
        n_queries++;
        if (key_mem[b] == key) r.q_count = count_mem[b];
      end else begin
        n_inserts++;
        if (count_mem[b] == 0) begin
          key_mem[b]    = key;
          count_mem[b]  = 1;
          reward_mem[b] = 1;
        end else if (key_mem[b] == key) begin
          count_mem[b]  = bump(count_mem[b]);
          reward_mem[b] = bump(reward_mem[b]);
        end else begin
          if (reward_mem[b] != 0) reward_mem[b] = reward_mem[b] - 1'b1;
          if (reward_mem[b] == 0) begin
            r.evicted     = 1'b1;
            r.ev_key      = key_mem[b];
            r.ev_total    = count_mem[b];
            key_mem[b]    = key;
            count_mem[b]  = 1;
            reward_mem[b] = 1;
            n_evictions++;
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void match_result(logic ev, logic [KEY_W-1:0] ek, logic [CNT_W-1:0] et,
                               logic [CNT_W-1:0] qc);
      flow_result_t r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none actual %h %h %h %h",
                 $time, ev, ek, et, qc);
        return;
      end
      r = expected_q.pop_front();
      check_field("evicted", 32'(r.evicted), 32'(ev));
      check_field("evicted_key", r.ev_key, ek);
      check_field("evicted_total", r.ev_total, et);
      check_field("query_count", r.q_count, qc);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n             = 1'b0;
  logic             start             = 1'b0;
  logic             in_req_type       = REQ_INSERT;
  logic [KEY_W-1:0] in_flow_key       = '0;
  logic             psel              = 1'b0;
  logic             penable           = 1'b0;
  logic             pwrite            = 1'b0;
  logic [2:0]       paddr             = '0;
  logic [31:0]      pwdata            = '0;
  logic             busy;
  logic             out_valid;
  logic             out_evicted;
  logic [KEY_W-1:0] out_evicted_key;
  logic [CNT_W-1:0] out_evicted_total;
  logic [CNT_W-1:0] out_query_count;
  logic [31:0]      prdata;
  logic             pready;

  flow_table_mirror mirror;
  logic [KEY_W-1:0] key_pool[POOL_N];
  int unsigned      item_no;
  int unsigned      quiet;

  heavy_flow_vote_table_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_flow_key       (in_flow_key),
    .out_valid         (out_valid),
    .out_evicted       (out_evicted),
    .out_evicted_key   (out_evicted_key),
    .out_evicted_total (out_evicted_total),
    .out_query_count   (out_query_count),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      mirror.match_result(out_evicted, out_evicted_key, out_evicted_total, out_query_count);
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("heavy_flow_vote_table_core test failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic req, input logic [KEY_W-1:0] key);
    start       <= 1'b1;
    in_req_type <= req;
    in_flow_key <= key;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    mirror.take_request(req, key);
    item_no++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    start       <= 1'b0;
    in_req_type <= 1'($urandom);
    in_flow_key <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    mirror.set_reg(addr >> 2, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // keys that crowd into a few buckets so that votes and evictions happen
  task automatic refill_pool();
    int unsigned t0, t1, t2, b, tries;
    logic [KEY_W-1:0] k;
    t0 = mirror.bucket_index($urandom);
    t1 = mirror.bucket_index($urandom);
    t2 = mirror.bucket_index($urandom);
    for (int i = 0; i < POOL_N; i++) begin
      tries = 0;
      do begin
        k = $urandom;
        b = mirror.bucket_index(k);
        tries++;
      end while (b != t0 && b != t1 && b != t2 && tries < 4096);
      key_pool[i] = k;
    end
  endtask

  task automatic random_item();
    int unsigned r;
    logic        req;
    logic [KEY_W-1:0] key;
    r   = $urandom_range(0, 99);
    req = ($urandom_range(0, 99) < 30) ? REQ_QUERY : REQ_INSERT;
    if (r < 80) key = key_pool[$urandom_range(0, POOL_N - 1)];
    else if (r < 92) key = $urandom;
    else if (r < 96) key = $urandom_range(0, 1) ? '1 : '0;
    else key = key_pool[$urandom_range(0, POOL_N - 1)] ^ (KEY_W'(1) << $urandom_range(0, 31));
    send_item(req, key);
  endtask

  initial begin
    logic [31:0] phase_cfg[N_PHASES];
    int unsigned pct;
    mirror  = new();
    item_no = 0;
    quiet   = 0;
    phase_cfg[0] = 32'hFFFF_F800;
    phase_cfg[1] = 32'h0000_0003;
    phase_cfg[2] = 32'h0000_0010;
    phase_cfg[3] = 32'h0000_0002;
    phase_cfg[4] = 32'hFFFF_F7FF;
    phase_cfg[5] = 32'h0000_0401;
    phase_cfg[6] = 32'h0000_03FF;
    phase_cfg[7] = ($urandom & 32'hFFFF_F800) | $urandom_range(1, 40);
    phase_cfg[8] = 32'h0000_0400;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // empty table at full size
    send_item(REQ_QUERY, '0);
    send_item(REQ_QUERY, '1);
    send_item(REQ_INSERT, '1);
    send_item(REQ_INSERT, '1);
    send_item(REQ_QUERY, '1);
    send_item(REQ_INSERT, '0);
    send_item(REQ_QUERY, '0);
    send_item(REQ_QUERY, 32'h0000_0001);
    drain();

    // zero bucket count: every flow fights over one bucket
    write_reg(BUCKETS_ADR, 32'h0000_0000);
    send_item(REQ_INSERT, 32'h1234_5678);
    send_item(REQ_INSERT, 32'h1234_5678);
    send_item(REQ_INSERT, 32'hA5A5_A5A5);
    send_item(REQ_INSERT, 32'hA5A5_A5A5);
    send_item(REQ_QUERY, 32'hA5A5_A5A5);
    send_item(REQ_INSERT, 32'hA5A5_A5A5);
    send_item(REQ_INSERT, 32'hA5A5_A5A5);
    send_item(REQ_QUERY, 32'h1234_5678);
    send_item(REQ_INSERT, 32'h5A5A_5A5A);
    send_item(REQ_INSERT, 32'h5A5A_5A5A);
    send_item(REQ_QUERY, 32'h5A5A_5A5A);
    drain();
    write_reg(UNUSED_ADR, 32'h0000_0002);
    send_item(REQ_INSERT, 32'h0F0F_0F0F);
    send_item(REQ_QUERY, 32'h0F0F_0F0F);
    send_item(REQ_INSERT, 32'hF0F0_F0F0);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(BUCKETS_ADR, phase_cfg[p]);
      refill_pool();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p < 3) pct = 28;
        else if (p < 6) pct = 68;
        else pct = 0;
        if ((i % 50) < 10) pct = 0;
        if (i == PHASE_ITEMS / 2 || $urandom_range(0, 99) == 0) drain();
        else if ($urandom_range(0, 99) < pct) hold_off($urandom_range(1, 45));
        random_item();
      end
      drain();
    end

    start <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d beats: %0d inserts and %0d queries, %0d evictions, %0d bucket settings",
             item_no, mirror.n_inserts, mirror.n_queries, mirror.n_evictions, mirror.n_settings);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("heavy_flow_vote_table_core test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mirror.errors, mirror.pending());
      $display("heavy_flow_vote_table_core test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/hfvt_pkg.sv
src/hfvt_ram.sv
src/hfvt_hash.sv
src/hfvt_mod.sv
src/heavy_flow_vote_table_core.sv
tb/sv/tb_heavy_flow_vote_table_core.sv
